### design/mlk_pkg.sv
package mlk_pkg;

  // Tick counter width; the unit compare is carried one bit wider than
  // the larger of this and the unit_ticks register
  localparam int TICK_COUNTER_WIDTH = 16;
  localparam int UNIT_TICKS_W       = 16;
  localparam int TICK_CMP_W         =
    ((TICK_COUNTER_WIDTH > UNIT_TICKS_W) ? TICK_COUNTER_WIDTH : UNIT_TICKS_W) + 1;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_TICKS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DASH_UNITS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_UNITS   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNKN_UNITS  = 2'd3;

  // Operation codes of an input word
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Keyer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;
  localparam logic [1:0] PH_GAP   = 2'd3;

  // ASCII bounds of lower-case letters
  localparam logic [7:0] ASCII_CASE_BIT = 8'h20;
  localparam logic [7:0] ASCII_LOW_A    = 8'h61;
  localparam logic [7:0] ASCII_LOW_Z    = 8'h7A;

  // One result word
  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic dropped;
  } mlk_res_t;

  // Letter table: bits 3:0 element pattern (msb first, 1 = dash), bits 6:4 length
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] code;
    case (idx)
      5'd0:    code = 8'h21;
      5'd1:    code = 8'h48;
      5'd2:    code = 8'h4A;
      5'd3:    code = 8'h34;
      5'd4:    code = 8'h10;
      5'd5:    code = 8'h42;
      5'd6:    code = 8'h36;
      5'd7:    code = 8'h40;
      5'd8:    code = 8'h20;
      5'd9:    code = 8'h47;
      5'd10:   code = 8'h35;
      5'd11:   code = 8'h44;
      5'd12:   code = 8'h23;
      5'd13:   code = 8'h22;
      5'd14:   code = 8'h37;
      5'd15:   code = 8'h46;
      5'd16:   code = 8'h4D;
      5'd17:   code = 8'h32;
      5'd18:   code = 8'h30;
      5'd19:   code = 8'h11;
      5'd20:   code = 8'h31;
      5'd21:   code = 8'h41;
      5'd22:   code = 8'h33;
      5'd23:   code = 8'h49;
      5'd24:   code = 8'h4B;
      5'd25:   code = 8'h4C;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

### design/mlk_if.sv
// Input channel: one word is a character offer or a time tick
interface mlk_in_if;
  import mlk_pkg::*;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] character;

  modport source (output valid, output operation, output character, input ready);
  modport sink   (input valid, input operation, input character, output ready);
endinterface

// Result channel: LED level and status after each input word
interface mlk_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;
  logic dropped;

  modport source (output valid, output led_on, output busy_res, output dropped,
                  input ready);
  modport sink   (input valid, input led_on, input busy_res, input dropped,
                  output ready);
endinterface

### design/mlk_core.sv
module mlk_core
  import mlk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   acc,
  input  logic                   operation,
  input  logic [7:0]             character,
  output mlk_res_t               res
);

  // Configuration registers
  logic [UNIT_TICKS_W-1:0] unit_ticks_r;
  logic [3:0]              dash_units_r;
  logic [3:0]              gap_units_r;
  logic [4:0]              unkn_units_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= 16'd333;
      dash_units_r <= 4'd3;
      gap_units_r  <= 4'd2;
      unkn_units_r <= 5'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_TICKS: unit_ticks_r <= cfg_data[UNIT_TICKS_W-1:0];
        REG_DASH_UNITS: dash_units_r <= cfg_data[3:0];
        REG_GAP_UNITS:  gap_units_r  <= cfg_data[3:0];
        REG_UNKN_UNITS: unkn_units_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Keyer state
  logic [3:0]                    pat_r, pat_nxt;
  logic [2:0]                    left_r, left_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic [TICK_COUNTER_WIDTH-1:0] tick_r, tick_nxt;
  logic [4:0]                    unit_r, unit_nxt;
  logic [4:0]                    seg_r, seg_nxt;

  // Decode helpers
  logic [7:0]                    low_c;
  logic                          is_letter_c;
  logic [7:0]                    code_c;
  logic [TICK_COUNTER_WIDTH-1:0] tick_inc_c;
  logic [TICK_CMP_W-1:0]         lim_c;
  logic [4:0]                    unit_inc_c;
  logic                          dropped_c;

  assign low_c       = character | ASCII_CASE_BIT;
  assign is_letter_c = (low_c >= ASCII_LOW_A) && (low_c <= ASCII_LOW_Z);
  assign code_c      = letter_code(5'(low_c - ASCII_LOW_A));
  assign tick_inc_c  = tick_r + 1'b1;
  assign lim_c       = (unit_ticks_r == '0) ? TICK_CMP_W'(1)
                                            : TICK_CMP_W'(unit_ticks_r);
  assign unit_inc_c  = unit_r + 5'd1;

  // Next state: one item, with empty segments skipped in the same pass
  always_comb begin
    logic       req_next;
    logic       ent_en;
    logic [1:0] ent_ph;
    logic [4:0] ent_units;
    logic       bit_dash;

    pat_nxt   = pat_r;
    left_nxt  = left_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    unit_nxt  = unit_r;
    seg_nxt   = seg_r;
    dropped_c = 1'b0;
    req_next  = 1'b0;
    ent_en    = 1'b0;
    ent_ph    = PH_IDLE;
    ent_units = 5'd0;
    bit_dash  = 1'b0;

    if (acc) begin
      if (operation == OP_CHAR) begin
        if (phase_r != PH_IDLE) begin
          dropped_c = 1'b1;
        end else if (is_letter_c) begin
          pat_nxt  = code_c[3:0];
          left_nxt = code_c[6:4];
          req_next = 1'b1;
        end else begin
          pat_nxt  = 4'd0;
          left_nxt = 3'd0;
          if (unkn_units_r == 5'd0) begin
            req_next = 1'b1;
          end else begin
            ent_en    = 1'b1;
            ent_ph    = PH_SPACE;
            ent_units = unkn_units_r;
          end
        end
      end else if (phase_r != PH_IDLE) begin
        if ((tick_inc_c == '0) || (TICK_CMP_W'(tick_inc_c) >= lim_c)) begin
          tick_nxt = '0;
          unit_nxt = unit_inc_c;
          if (unit_inc_c >= seg_r) begin
            case (phase_r)
              PH_MARK: begin
                ent_en    = 1'b1;
                ent_ph    = PH_SPACE;
                ent_units = 5'd1;
              end
              PH_SPACE: req_next = 1'b1;
              default: begin
                ent_en = 1'b1;
                ent_ph = PH_IDLE;
              end
            endcase
          end
        end else begin
          tick_nxt = tick_inc_c;
        end
      end
    end

    // Advance to the next element, or after the last one to the letter gap (idle if it is zero)
    if (req_next) begin
      ent_en = 1'b1;
      if (left_nxt == 3'd0) begin
        if (gap_units_r == 4'd0) begin
          ent_ph = PH_IDLE;
        end else begin
          ent_ph    = PH_GAP;
          ent_units = 5'(gap_units_r);
        end
      end else begin
        bit_dash = pat_nxt[2'(left_nxt - 3'd1)];
        left_nxt = left_nxt - 3'd1;
        if (!bit_dash) begin
          ent_ph    = PH_MARK;
          ent_units = 5'd1;
        end else if (dash_units_r == 4'd0) begin
          ent_ph    = PH_SPACE;
          ent_units = 5'd1;
        end else begin
          ent_ph    = PH_MARK;
          ent_units = 5'(dash_units_r);
        end
      end
    end

    if (ent_en) begin
      phase_nxt = ent_ph;
      seg_nxt   = ent_units;
      tick_nxt  = '0;
      unit_nxt  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= 4'd0;
      left_r  <= 3'd0;
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      unit_r  <= 5'd0;
      seg_r   <= 5'd0;
    end else begin
      pat_r   <= pat_nxt;
      left_r  <= left_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      unit_r  <= unit_nxt;
      seg_r   <= seg_nxt;
    end
  end

  // Result for the word handled this cycle
  assign res.led_on   = (phase_nxt == PH_MARK);
  assign res.busy_res = (phase_nxt != PH_IDLE);
  assign res.dropped  = dropped_c;

endmodule

### design/morse_led_keyer_unit.sv
// Morse code LED keyer.
// in_ch carries words of two kinds: a character offer (operation 0) or one
// time tick (operation 1). A character offered while idle is keyed out as
// Morse code, letters in either case; any other code keys dark time only.
// A character offered while busy is ignored and reported as dropped.
// Each input word gives exactly one result word on out_ch: the LED level,
// the busy flag and the dropped flag after that word.
// cfg_we/cfg_index/cfg_data write the timing registers (unit_ticks,
// dash_units, letter_gap_units, unknown_units); write them only while idle.
// Latency: the result is valid the cycle after its word is accepted unless
// it waits in the skid register. One word per cycle while in_ch.ready is
// high; keyer state updates in one pass of counter compares and the letter
// table. Stall: an output register plus one skid register hold results;
// in_ch.ready drops only while both are full, and rises again once out_ch
// takes a word. Reset (rst_n low, synchronous): keyer idle, LED dark,
// registers at their defaults, both result registers empty.
module morse_led_keyer_unit
  import mlk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  mlk_in_if.sink                 in_ch,
  mlk_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic     acc;
  logic     take;
  mlk_res_t res_c;
  mlk_res_t out_r;
  mlk_res_t skid_r;
  logic     out_valid_r;
  logic     skid_valid_r;

  assign in_ch.ready = !skid_valid_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign take        = out_valid_r && out_ch.ready;

  mlk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .operation (in_ch.operation),
    .character (in_ch.character),
    .res       (res_c)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: new word goes to output if it frees up, else to skid
  always_ff @(posedge clk) begin
    if (acc) begin
      if (!out_valid_r || take) begin
        out_r <= res_c;
      end else begin
        skid_r <= res_c;
      end
    end else if (take && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.led_on   = out_r.led_on;
  assign out_ch.busy_res = out_r.busy_res;
  assign out_ch.dropped  = out_r.dropped;

endmodule

### design/mlk_checker.sv
module mlk_checker
  import mlk_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_operation,
  input logic out_valid,
  input logic out_ready,
  input logic out_led_on,
  input logic out_busy_res,
  input logic out_dropped
);

  // Held result word stays put while stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_on)
      && $stable(out_busy_res) && $stable(out_dropped))
    else $error("result word changed while stalled");

  // Lit LED only while a character is in progress
  a_led_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_led_on || out_busy_res)
    else $error("LED lit while not busy");

  // Input back-pressure only with a pending result
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A tick word that goes straight to the output register never reports a drop
  a_tick_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_TICK) && (!out_valid || out_ready)
      |=> out_valid && !out_dropped)
    else $error("tick word flagged as dropped");

  // A character that goes straight to the output register and is dropped leaves the keyer busy
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_CHAR) && (!out_valid || out_ready)
      |=> out_valid && (!out_dropped || out_busy_res))
    else $error("character dropped while idle");

endmodule

bind morse_led_keyer_unit mlk_checker u_mlk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_led_on   (out_ch.led_on),
  .out_busy_res (out_ch.busy_res),
  .out_dropped  (out_ch.dropped)
);
